>>> rtl/ppa_pkg.sv
package ppa_pkg;

  // coordinate and difference widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIFF_W  = COORD_W + 1;  // exact signed difference
  localparam int unsigned MAG_W   = COORD_W;      // |difference| stays below 2^32
  localparam int unsigned SUM_W   = MAG_W + 1;    // |dx| + |dy|
  localparam int unsigned ANGLE_W = 32;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_Y = 1'd1;

  // per-point flags carried alongside the divider
  typedef struct packed {
    logic zero;    // point sits on the view origin
    logic dx_neg;  // left half plane
    logic dy_neg;  // lower half plane
  } ppa_flags_t;

endpackage

>>> rtl/ppa_front.sv
module ppa_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [ppa_pkg::COORD_W-1:0]  view_x,
  input  logic signed [ppa_pkg::COORD_W-1:0]  view_y,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ppa_pkg::COORD_W-1:0]  point_x,
  input  logic signed [ppa_pkg::COORD_W-1:0]  point_y,
  output logic                                v_out,
  input  logic                                rdy_dn,
  output logic [ppa_pkg::SUM_W-1:0]           rem_out,
  output logic [ppa_pkg::SUM_W-1:0]           div_out,
  output ppa_pkg::ppa_flags_t                 flags_out
);

  // stage a: differences
  logic                               a_v;
  logic                               a_rdy;
  logic signed [ppa_pkg::DIFF_W-1:0]  a_dx;
  logic signed [ppa_pkg::DIFF_W-1:0]  a_dy;

  // stage b: magnitudes, sum and flags
  logic                               b_v;
  logic                               b_rdy;
  logic [ppa_pkg::MAG_W-1:0]          b_dy_mag;
  logic [ppa_pkg::SUM_W-1:0]          b_sum;
  ppa_pkg::ppa_flags_t                b_flags;

  logic signed [ppa_pkg::DIFF_W-1:0]  dx_next;
  logic signed [ppa_pkg::DIFF_W-1:0]  dy_next;
  logic [ppa_pkg::DIFF_W-1:0]         dx_negated;
  logic [ppa_pkg::DIFF_W-1:0]         dy_negated;
  logic [ppa_pkg::MAG_W-1:0]          dx_mag;
  logic [ppa_pkg::MAG_W-1:0]          dy_mag;

  assign a_rdy    = !a_v || b_rdy;
  assign b_rdy    = !b_v || rdy_dn;
  assign in_stall = !a_rdy;

  assign dx_next = ppa_pkg::DIFF_W'(point_x) - ppa_pkg::DIFF_W'(view_x);
  assign dy_next = ppa_pkg::DIFF_W'(point_y) - ppa_pkg::DIFF_W'(view_y);

  assign dx_negated = -a_dx;
  assign dy_negated = -a_dy;
  assign dx_mag = a_dx[ppa_pkg::DIFF_W-1] ? dx_negated[ppa_pkg::MAG_W-1:0]
                                          : a_dx[ppa_pkg::MAG_W-1:0];
  assign dy_mag = a_dy[ppa_pkg::DIFF_W-1] ? dy_negated[ppa_pkg::MAG_W-1:0]
                                          : a_dy[ppa_pkg::MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else begin
      if (a_rdy) a_v <= in_valid;
      if (b_rdy) b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_dx <= dx_next;
      a_dy <= dy_next;
    end
    if (b_rdy) begin
      b_dy_mag       <= dy_mag;
      b_sum          <= {1'b0, dx_mag} + {1'b0, dy_mag};
      b_flags.zero   <= (a_dx == '0) && (a_dy == '0);
      b_flags.dx_neg <= a_dx[ppa_pkg::DIFF_W-1];
      b_flags.dy_neg <= a_dy[ppa_pkg::DIFF_W-1];
    end
  end

  assign v_out     = b_v;
  assign rem_out   = {1'b0, b_dy_mag};
  assign div_out   = b_sum;
  assign flags_out = b_flags;

endmodule

>>> rtl/ppa_div_step.sv
module ppa_div_step #(
  parameter int unsigned Q_W    = 31,
  parameter bit          DOUBLE = 1'b1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       v_in,
  output logic                       rdy_up,
  input  logic [ppa_pkg::SUM_W-1:0]  rem_in,
  input  logic [ppa_pkg::SUM_W-1:0]  div_in,
  input  logic [Q_W-1:0]             q_in,
  input  ppa_pkg::ppa_flags_t        flags_in,
  output logic                       v_out,
  input  logic                       rdy_dn,
  output logic [ppa_pkg::SUM_W-1:0]  rem_out,
  output logic [ppa_pkg::SUM_W-1:0]  div_out,
  output logic [Q_W-1:0]             q_out,
  output ppa_pkg::ppa_flags_t        flags_out
);

  logic                       v;
  logic [ppa_pkg::SUM_W:0]    trial;
  logic [ppa_pkg::SUM_W:0]    diff;
  logic                       fits;

  // restoring step: partial remainder stays below the divisor
  assign trial = DOUBLE ? {rem_in, 1'b0} : {1'b0, rem_in};
  assign diff  = trial - {1'b0, div_in};
  assign fits  = trial >= {1'b0, div_in};

  assign rdy_up = !v || rdy_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (rdy_up) begin
      v <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_up) begin
      rem_out   <= fits ? diff[ppa_pkg::SUM_W-1:0] : trial[ppa_pkg::SUM_W-1:0];
      div_out   <= div_in;
      q_out     <= {q_in[Q_W-2:0], fits};
      flags_out <= flags_in;
    end
  end

  assign v_out = v;

endmodule

>>> rtl/ppa_back.sv
module ppa_back #(
  parameter int unsigned FRACTION_BITS = 30
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         v_in,
  output logic                         rdy_up,
  input  logic [ppa_pkg::SUM_W-1:0]    rem_in,
  input  logic [FRACTION_BITS:0]       q_in,
  input  ppa_pkg::ppa_flags_t          flags_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ppa_pkg::ANGLE_W-1:0]  pseudo_angle
);

  localparam logic [ppa_pkg::ANGLE_W-1:0] HALF_TURN =
    ppa_pkg::ANGLE_W'(1) << (FRACTION_BITS + 1);

  logic [ppa_pkg::ANGLE_W-1:0] q_wide;
  logic [ppa_pkg::ANGLE_W-1:0] round_up;
  logic [ppa_pkg::ANGLE_W-1:0] angle_next;

  assign q_wide   = ppa_pkg::ANGLE_W'(q_in);
  assign round_up = ppa_pkg::ANGLE_W'(rem_in != '0);

  always_comb begin
    if (flags_in.zero) begin
      angle_next = '0;
    end else if (!flags_in.dx_neg) begin
      angle_next = flags_in.dy_neg ? -q_wide : q_wide;
    end else begin
      // mirror: 2 - r (quotient rounded up) or, for dy < 0, 2 + r
      angle_next = flags_in.dy_neg ? HALF_TURN + q_wide
                                   : HALF_TURN - q_wide - round_up;
    end
  end

  assign rdy_up = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_up) begin
      out_valid <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_up) pseudo_angle <= angle_next;
  end

endmodule

>>> rtl/point_pseudo_angle.sv
// pseudo-angle of a point around a programmable view origin: each transfer
// on the input side carries one 16.16 point, and one 32-bit pseudo-angle
// comes out per point, in order, with 2^FRACTION_BITS per quarter turn
// (ordered like the true angle, negative values wrapping mod 2^32, and 0 for
// a point on the origin). the block takes one point every clock while the
// output is not stalled: the front end registers the differences and then
// |dx| + |dy|, a restoring divider with one stage per quotient bit
// (FRACTION_BITS + 1 stages) produces |dy| / (|dx| + |dy|), and ppa_back
// applies the half-plane fix-up into the output register. every stage holds
// a valid bit and advances when its successor is empty or moving, so a stall
// at the output fills bubbles first and only then holds off the input. the
// view origin registers are written through cfg_write / cfg_index / cfg_data
// and must only change while no point is in flight
module point_pseudo_angle #(
  parameter int unsigned FRACTION_BITS = 30
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_write,
  input  logic [ppa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ppa_pkg::COORD_W-1:0]           cfg_data,
  // point input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [ppa_pkg::COORD_W-1:0]    point_x,
  input  logic signed [ppa_pkg::COORD_W-1:0]    point_y,
  // pseudo-angle output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ppa_pkg::ANGLE_W-1:0]           pseudo_angle
);

  // one divider stage per quotient bit, integer bit included
  localparam int unsigned STEPS = FRACTION_BITS + 1;
  localparam int unsigned Q_W   = FRACTION_BITS + 1;

  logic signed [ppa_pkg::COORD_W-1:0] view_x;
  logic signed [ppa_pkg::COORD_W-1:0] view_y;

  // view origin registers
  always_ff @(posedge clk) begin
    if (rst) begin
      view_x <= '0;
      view_y <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        ppa_pkg::REG_VIEW_X: view_x <= cfg_data;
        ppa_pkg::REG_VIEW_Y: view_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // chain between the front end, divider stages and output stage
  logic                       v_s     [0:STEPS];
  logic                       rdy_s   [0:STEPS];
  logic [ppa_pkg::SUM_W-1:0]  rem_s   [0:STEPS];
  logic [ppa_pkg::SUM_W-1:0]  div_s   [0:STEPS];
  logic [Q_W-1:0]             q_s     [0:STEPS];
  ppa_pkg::ppa_flags_t        flags_s [0:STEPS];

  // differences, magnitudes and divisor |dx| + |dy|
  ppa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .view_x    (view_x),
    .view_y    (view_y),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .point_x   (point_x),
    .point_y   (point_y),
    .v_out     (v_s[0]),
    .rdy_dn    (rdy_s[0]),
    .rem_out   (rem_s[0]),
    .div_out   (div_s[0]),
    .flags_out (flags_s[0])
  );

  // quotient starts empty and fills msb first
  assign q_s[0] = '0;

  // since |dy| <= divisor, the first stage compares without doubling and
  // yields the integer bit; the rest each add one fraction bit
  for (genvar i = 0; i < STEPS; i++) begin : g_div
    ppa_div_step #(
      .Q_W    (Q_W),
      .DOUBLE (i != 0)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .v_in      (v_s[i]),
      .rdy_up    (rdy_s[i]),
      .rem_in    (rem_s[i]),
      .div_in    (div_s[i]),
      .q_in      (q_s[i]),
      .flags_in  (flags_s[i]),
      .v_out     (v_s[i+1]),
      .rdy_dn    (rdy_s[i+1]),
      .rem_out   (rem_s[i+1]),
      .div_out   (div_s[i+1]),
      .q_out     (q_s[i+1]),
      .flags_out (flags_s[i+1])
    );
  end

  // sign and half-plane fix-up, output register
  ppa_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .v_in         (v_s[STEPS]),
    .rdy_up       (rdy_s[STEPS]),
    .rem_in       (rem_s[STEPS]),
    .q_in         (q_s[STEPS]),
    .flags_in     (flags_s[STEPS]),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pseudo_angle (pseudo_angle)
  );

endmodule
